// ===== rtl/cpfr_pkg.sv =====
// shared types and constants for the complex polynomial from roots core
package cpfr_pkg;

  localparam int ROOT_W  = 32;
  localparam int COEF_W  = 64;
  localparam int INDEX_W = 6;
  localparam int MUL_W   = 33;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int ACC_W   = 100;
  localparam int FRAC_SH = 16;
  localparam int HALF_SH = 32;

  localparam logic signed [COEF_W-1:0] ONE_Q32  = 64'sh0000_0001_0000_0000;
  localparam logic signed [COEF_W-1:0] COEF_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [COEF_W-1:0] COEF_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic       init;
    logic       issue;
    logic [2:0] step;
  } mac_ctl_t;

endpackage

// ===== rtl/complex_polynomial_from_roots_core.sv =====
// top level: sequencer for root updates and the coefficient output run
// root update: each of the n stored coefficients (n = roots so far + 1) is read, loaded, built
//   and written back by the single shared 33x33 multiplier doing 8 partial products per coefficient
// output run: root_count+1 words, each a memory read, a load, then a send held until out_ready
// throughput: one root at a time; in_ready is high only while idle
// reset: clears the root count and both sticky flags; the store needs no clearing pass,
//   entries above the count are never read and entry 0 reads as one
module complex_polynomial_from_roots_core #(
  parameter int MAX_ROOTS = 63
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [cpfr_pkg::ROOT_W-1:0]    root_re,
  input  logic signed [cpfr_pkg::ROOT_W-1:0]    root_im,
  input  logic                                  last_root,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [cpfr_pkg::COEF_W-1:0]    coef_re,
  output logic signed [cpfr_pkg::COEF_W-1:0]    coef_im,
  output logic [cpfr_pkg::INDEX_W-1:0]          coef_index,
  output logic                                  last_coef,
  output logic                                  saturated,
  output logic                                  roots_dropped
);

  localparam int DEPTH  = MAX_ROOTS + 1;
  localparam int ADDR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RD   = 8'b0000_0010,
    S_LD   = 8'b0000_0100,
    S_MAC  = 8'b0000_1000,
    S_FIN  = 8'b0001_0000,
    S_ORD  = 8'b0010_0000,
    S_OLD  = 8'b0100_0000,
    S_OWT  = 8'b1000_0000
  } state_t;

  state_t                               state;
  logic [ADDR_W-1:0]                    root_count;
  logic                                 sat_sticky;
  logic                                 drop_sticky;
  logic                                 last_flag;
  logic signed [cpfr_pkg::ROOT_W-1:0]   rr;
  logic signed [cpfr_pkg::ROOT_W-1:0]   ri;
  logic [ADDR_W-1:0]                    p;
  logic [ADDR_W-1:0]                    k;
  logic [3:0]                           cnt;
  logic signed [cpfr_pkg::COEF_W-1:0]   cur_re;
  logic signed [cpfr_pkg::COEF_W-1:0]   cur_im;
  logic signed [cpfr_pkg::COEF_W-1:0]   prv_re;
  logic signed [cpfr_pkg::COEF_W-1:0]   prv_im;

  logic [ADDR_W-1:0]                    pm1;
  logic [ADDR_W-1:0]                    raddr;
  logic signed [cpfr_pkg::COEF_W-1:0]   rd_re;
  logic signed [cpfr_pkg::COEF_W-1:0]   rd_im;
  logic signed [cpfr_pkg::COEF_W-1:0]   new_re;
  logic signed [cpfr_pkg::COEF_W-1:0]   new_im;
  logic                                 mac_sat;
  logic                                 store_we;
  cpfr_pkg::mac_ctl_t                   mac_ctl;

  assign in_ready = (state == S_IDLE);
  assign pm1      = p - 1'b1;
  assign raddr    = (state == S_ORD) ? k : pm1;
  assign store_we = (state == S_FIN);

  always_comb begin
    mac_ctl.init  = (state == S_LD);
    mac_ctl.issue = (state == S_MAC) && !cnt[3];
    mac_ctl.step  = cnt[2:0];
  end

  cpfr_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk      (clk),
    .we       (store_we),
    .waddr    (p),
    .wdata_re (new_re),
    .wdata_im (new_im),
    .raddr    (raddr),
    .rdata_re (rd_re),
    .rdata_im (rd_im)
  );

  cpfr_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mac_ctl),
    .rr     (rr),
    .ri     (ri),
    .pr     (prv_re),
    .pi     (prv_im),
    .cur_re (cur_re),
    .cur_im (cur_im),
    .new_re (new_re),
    .new_im (new_im),
    .sat    (mac_sat)
  );

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        rr        <= root_re;
        ri        <= root_im;
        last_flag <= last_root;
        p         <= root_count + 1'b1;
        k         <= '0;
        cur_re    <= '0;
        cur_im    <= '0;
      end
      S_LD: begin
        // entry 0 is the fixed leading one
        prv_re <= (pm1 == '0) ? cpfr_pkg::ONE_Q32 : rd_re;
        prv_im <= (pm1 == '0) ? '0 : rd_im;
        cnt    <= '0;
      end
      S_MAC: begin
        cnt <= cnt + 1'b1;
      end
      S_FIN: begin
        cur_re <= prv_re;
        cur_im <= prv_im;
        p      <= pm1;
      end
      S_OLD: begin
        coef_re       <= (k == '0) ? cpfr_pkg::ONE_Q32 : rd_re;
        coef_im       <= (k == '0) ? '0 : rd_im;
        coef_index    <= cpfr_pkg::INDEX_W'(k);
        last_coef     <= (k == root_count);
        saturated     <= sat_sticky;
        roots_dropped <= drop_sticky;
      end
      S_OWT: begin
        if (out_ready) begin
          k <= k + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      root_count  <= '0;
      sat_sticky  <= 1'b0;
      drop_sticky <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (root_count < ADDR_W'(MAX_ROOTS)) begin
              state <= S_RD;
            end else begin
              drop_sticky <= 1'b1;
              state       <= last_root ? S_ORD : S_IDLE;
            end
          end
        end
        S_RD: begin
          state <= S_LD;
        end
        S_LD: begin
          state <= S_MAC;
        end
        S_MAC: begin
          if (cnt[3]) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          sat_sticky <= sat_sticky | mac_sat;
          if (pm1 == '0) begin
            root_count <= root_count + 1'b1;
            state      <= last_flag ? S_ORD : S_IDLE;
          end else begin
            state <= S_RD;
          end
        end
        S_ORD: begin
          state <= S_OLD;
        end
        S_OLD: begin
          out_valid <= 1'b1;
          state     <= S_OWT;
        end
        S_OWT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (k == root_count) begin
              // run done, start a fresh set
              root_count  <= '0;
              sat_sticky  <= 1'b0;
              drop_sticky <= 1'b0;
              state       <= S_IDLE;
            end else begin
              state <= S_ORD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/cpfr_store.sv =====
// complex coefficient memory, one write port and one registered read port
module cpfr_store #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [ADDR_W-1:0]                    waddr,
  input  logic signed [cpfr_pkg::COEF_W-1:0]   wdata_re,
  input  logic signed [cpfr_pkg::COEF_W-1:0]   wdata_im,
  input  logic [ADDR_W-1:0]                    raddr,
  output logic signed [cpfr_pkg::COEF_W-1:0]   rdata_re,
  output logic signed [cpfr_pkg::COEF_W-1:0]   rdata_im
);

  logic signed [cpfr_pkg::COEF_W-1:0] mem_re [DEPTH];
  logic signed [cpfr_pkg::COEF_W-1:0] mem_im [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_re[waddr] <= wdata_re;
      mem_im[waddr] <= wdata_im;
    end
    rdata_re <= mem_re[raddr];
    rdata_im <= mem_im[raddr];
  end

endmodule

// ===== rtl/cpfr_mac.sv =====
// shared 33x33 multiplier with complex accumulators and output saturation
module cpfr_mac (
  input  logic                                 clk,
  input  logic                                 rst,
  input  cpfr_pkg::mac_ctl_t                   ctl,
  input  logic signed [cpfr_pkg::ROOT_W-1:0]   rr,
  input  logic signed [cpfr_pkg::ROOT_W-1:0]   ri,
  input  logic signed [cpfr_pkg::COEF_W-1:0]   pr,
  input  logic signed [cpfr_pkg::COEF_W-1:0]   pi,
  input  logic signed [cpfr_pkg::COEF_W-1:0]   cur_re,
  input  logic signed [cpfr_pkg::COEF_W-1:0]   cur_im,
  output logic signed [cpfr_pkg::COEF_W-1:0]   new_re,
  output logic signed [cpfr_pkg::COEF_W-1:0]   new_im,
  output logic                                 sat
);

  localparam int ACC_W = cpfr_pkg::ACC_W;
  localparam int TOP_LO = cpfr_pkg::FRAC_SH + cpfr_pkg::COEF_W - 1;

  logic signed [ACC_W-1:0]              acc_re;
  logic signed [ACC_W-1:0]              acc_im;
  logic signed [cpfr_pkg::PROD_W-1:0]   prod;
  logic                                 tag_valid;
  logic                                 tag_neg;
  logic                                 tag_hi;
  logic                                 tag_im;

  logic signed [cpfr_pkg::ROOT_W-1:0]   op_a;
  logic signed [cpfr_pkg::COEF_W-1:0]   op_x;
  logic signed [cpfr_pkg::MUL_W-1:0]    mul_a;
  logic signed [cpfr_pkg::MUL_W-1:0]    mul_b;
  logic signed [ACC_W-1:0]              term;
  logic signed [ACC_W-1:0]              acc_sel;
  logic signed [ACC_W-1:0]              acc_sum;
  logic                                 fit_re;
  logic                                 fit_im;

  // step order: -rr*pr, +ri*pi into re; -rr*pi, -ri*pr into im; low half then high half
  always_comb begin
    op_a  = ctl.step[1] ? ri : rr;
    op_x  = (ctl.step[1] ^ ctl.step[2]) ? pi : pr;
    mul_a = {op_a[cpfr_pkg::ROOT_W-1], op_a};
    if (ctl.step[0]) begin
      mul_b = {op_x[cpfr_pkg::COEF_W-1], op_x[cpfr_pkg::COEF_W-1:cpfr_pkg::HALF_SH]};
    end else begin
      mul_b = {1'b0, op_x[cpfr_pkg::HALF_SH-1:0]};
    end
  end

  always_comb begin
    term = ACC_W'(prod);
    if (tag_hi) begin
      term = term <<< cpfr_pkg::HALF_SH;
    end
    acc_sel = tag_im ? acc_im : acc_re;
    acc_sum = tag_neg ? acc_sel - term : acc_sel + term;
  end

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      prod    <= mul_a * mul_b;
      tag_neg <= !(!ctl.step[2] && ctl.step[1]);
      tag_hi  <= ctl.step[0];
      tag_im  <= ctl.step[2];
    end
    if (ctl.init) begin
      acc_re <= ACC_W'(cur_re) <<< cpfr_pkg::FRAC_SH;
      acc_im <= ACC_W'(cur_im) <<< cpfr_pkg::FRAC_SH;
    end else if (tag_valid) begin
      if (tag_im) begin
        acc_im <= acc_sum;
      end else begin
        acc_re <= acc_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_valid <= 1'b0;
    end else begin
      tag_valid <= ctl.issue && !ctl.init;
    end
  end

  // shift right by 16 then clip to 64 bits
  always_comb begin
    fit_re = (&acc_re[ACC_W-1:TOP_LO]) || !(|acc_re[ACC_W-1:TOP_LO]);
    fit_im = (&acc_im[ACC_W-1:TOP_LO]) || !(|acc_im[ACC_W-1:TOP_LO]);
    if (fit_re) begin
      new_re = acc_re[TOP_LO:cpfr_pkg::FRAC_SH];
    end else begin
      new_re = acc_re[ACC_W-1] ? cpfr_pkg::COEF_MIN : cpfr_pkg::COEF_MAX;
    end
    if (fit_im) begin
      new_im = acc_im[TOP_LO:cpfr_pkg::FRAC_SH];
    end else begin
      new_im = acc_im[ACC_W-1] ? cpfr_pkg::COEF_MIN : cpfr_pkg::COEF_MAX;
    end
    sat = !fit_re || !fit_im;
  end

endmodule

// ===== sim/complex_polynomial_from_roots_core_test.sv =====
// testbench for the complex polynomial from roots core: root sets in, checked coefficients out
`timescale 1ns / 1ps

module complex_polynomial_from_roots_core_test;

  localparam int STORE_DEPTH    = 64;
  localparam int ROOT_CAP       = 63;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 800;

  localparam logic signed [31:0] ROOT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ROOT_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE_Q16  = 32'sh0001_0000;

  typedef struct {
    logic signed [63:0] re;
    logic signed [63:0] im;
    logic [5:0]         index;
    logic               last;
    logic               sat;
    logic               drop;
  } coef_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] root_re = '0;
  logic signed [31:0] root_im = '0;
  logic last_root = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [63:0] coef_re;
  logic signed [63:0] coef_im;
  logic [5:0] coef_index;
  logic last_coef;
  logic saturated;
  logic roots_dropped;

  // polynomial state kept alongside the block
  logic signed [63:0] poly_re [STORE_DEPTH];
  logic signed [63:0] poly_im [STORE_DEPTH];
  int   stored_roots;
  logic sat_flag;
  logic drop_flag;

  coef_word_t pending_coefs[$];
  int mismatches = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  complex_polynomial_from_roots_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .root_re(root_re),
    .root_im(root_im),
    .last_root(last_root),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .coef_re(coef_re),
    .coef_im(coef_im),
    .coef_index(coef_index),
    .last_coef(last_coef),
    .saturated(saturated),
    .roots_dropped(roots_dropped)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void clear_poly();
    for (int i = 0; i < STORE_DEPTH; i++) begin
      poly_re[i] = '0;
      poly_im[i] = '0;
    end
    poly_re[0] = cpfr_pkg::ONE_Q32;
    stored_roots = 0;
    sat_flag = 1'b0;
    drop_flag = 1'b0;
  endfunction

  function automatic logic signed [63:0] clip_q32(input logic signed [127:0] v);
    if (v > cpfr_pkg::COEF_MAX) begin
      sat_flag = 1'b1;
      return cpfr_pkg::COEF_MAX;
    end
    if (v < cpfr_pkg::COEF_MIN) begin
      sat_flag = 1'b1;
      return cpfr_pkg::COEF_MIN;
    end
    return v[63:0];
  endfunction

  // multiply the polynomial by (x - root), then queue the coefficients on the closing root
  function automatic void multiply_by_root(input logic signed [31:0] rr,
                                           input logic signed [31:0] ri,
                                           input logic last);
    logic signed [127:0] wr, wi, pr, pi, cr, ci, acc_re, acc_im;
    coef_word_t word;
    int top;
    if (stored_roots < ROOT_CAP) begin
      top = stored_roots + 1;
      poly_re[top] = '0;
      poly_im[top] = '0;
      wr = rr;
      wi = ri;
      // top down so each step still reads the old lower coefficient
      for (int p = top; p > 0; p--) begin
        pr = poly_re[p-1];
        pi = poly_im[p-1];
        cr = poly_re[p];
        ci = poly_im[p];
        acc_re = (cr <<< 16) - wr * pr + wi * pi;
        acc_im = (ci <<< 16) - wr * pi - wi * pr;
        poly_re[p] = clip_q32(acc_re >>> 16);
        poly_im[p] = clip_q32(acc_im >>> 16);
      end
      stored_roots = top;
    end else begin
      drop_flag = 1'b1;
    end
    if (last) begin
      for (int k = 0; k <= stored_roots; k++) begin
        word.re = poly_re[k];
        word.im = poly_im[k];
        word.index = 6'(k);
        word.last = (k == stored_roots);
        word.sat = sat_flag;
        word.drop = drop_flag;
        pending_coefs.push_back(word);
      end
      clear_poly();
    end
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s mismatch, got %h expected %h", $time, field, got, want);
    mismatches++;
  endtask

  task automatic send_root(input logic signed [31:0] re, input logic signed [31:0] im,
                           input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    root_re = re;
    root_im = im;
    last_root = last;
    do @(posedge clk); while (!in_ready);
    multiply_by_root(re, im, last);
  endtask

  // hold the sender off until every coefficient owed has been taken
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_coefs.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_part();
    case ($urandom_range(7))
      0, 1: return $urandom;
      2: return '0;
      3: return (32'($urandom_range(16)) - 32'd8) << 16;
      default: return $urandom_range(0, 1 << 19) - (1 << 18);
    endcase
  endfunction

  task automatic test_extreme_roots();
    send_root('0, '0, 1'b1);
    send_root(ROOT_MAX, ROOT_MAX, 1'b1);
    send_root(ROOT_MIN, ROOT_MIN, 1'b1);
    send_root(ROOT_MAX, ROOT_MIN, 1'b0);
    send_root(ROOT_MIN, ROOT_MAX, 1'b1);
    // real root, then a conjugate pair giving real coefficients
    send_root(ONE_Q16, '0, 1'b1);
    send_root(32'sh0001_8000, 32'sh0002_0000, 1'b0);
    send_root(32'sh0001_8000, -32'sh0002_0000, 1'b1);
    // smallest fractions, exercises the floor on the shift
    send_root(32'sh0000_0001, -32'sh0000_0001, 1'b0);
    send_root(-32'sh0000_0001, 32'sh0000_0001, 1'b1);
    // large roots overflow the Q32.32 range
    for (int i = 0; i < 4; i++) send_root(ROOT_MIN, '0, i == 3);
    for (int i = 0; i < 3; i++) send_root(ROOT_MAX, ROOT_MAX, i == 2);
  endtask

  task automatic test_store_capacity(input int extra);
    int total;
    total = ROOT_CAP + extra;
    for (int i = 0; i < total; i++) send_root(rand_part(), rand_part(), i == total - 1);
  endtask

  task automatic test_random_sets(input int n_items);
    int sent, set_len;
    logic [31:0] im;
    sent = 0;
    while (sent < n_items) begin
      set_len = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
      for (int i = 0; i < set_len; i++) begin
        im = ($urandom_range(3) == 0) ? '0 : rand_part();
        send_root(rand_part(), im, i == set_len - 1);
      end
      sent += set_len;
    end
  endtask

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_words
    coef_word_t want;
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_valid && out_ready) begin
        if (pending_coefs.size() == 0) begin
          report_mismatch("unexpected word, coef_index", 64'(coef_index), '0);
        end else begin
          want = pending_coefs.pop_front();
          if (coef_re !== want.re) report_mismatch("coef_re", coef_re, want.re);
          if (coef_im !== want.im) report_mismatch("coef_im", coef_im, want.im);
          if (coef_index !== want.index)
            report_mismatch("coef_index", 64'(coef_index), 64'(want.index));
          if (last_coef !== want.last)
            report_mismatch("last_coef", 64'(last_coef), 64'(want.last));
          if (saturated !== want.sat)
            report_mismatch("saturated", 64'(saturated), 64'(want.sat));
          if (roots_dropped !== want.drop)
            report_mismatch("roots_dropped", 64'(roots_dropped), 64'(want.drop));
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("complex_polynomial_from_roots_core test failed");
        $finish;
      end
    end
  end

  initial begin
    clear_poly();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_extreme_roots();
    test_store_capacity(0);
    wait_for_drain();

    send_idle_pct = 71;
    test_random_sets(60);
    wait_for_drain();

    send_idle_pct = 0;
    recv_stall_pct = 71;
    test_random_sets(60);
    wait_for_drain();

    send_idle_pct = 20;
    recv_stall_pct = 20;
    test_random_sets(60);
    // overflow the store, closing root is itself dropped
    test_store_capacity(3);
    wait_for_drain();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_sets(60);
    wait_for_drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("complex_polynomial_from_roots_core test passed");
    end else begin
      $display("complex_polynomial_from_roots_core test failed");
    end
    $finish;
  end

endmodule
